[rtl/csq_pkg.sv]
// ----------------------------------------------------------------------------
// csq_pkg
// Shared types and constants for the counting semaphore wait queue.
// ----------------------------------------------------------------------------
package csq_pkg;

    localparam int NUM_PROCS_DEF   = 16;
    localparam int COUNT_WIDTH_DEF = 16;
    localparam int REF_WIDTH_DEF   = 8;

    localparam int FUNC_W    = 2;
    localparam int PROC_ID_W = 4;
    localparam int FAULT_W   = 2;
    localparam int APB_DW    = 32;
    localparam int APB_AW    = 3;

    localparam logic [FUNC_W-1:0] FUNC_WAIT   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_SIGNAL = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_READ   = 2'd2;

    localparam logic REG_INITIAL_COUNT = 1'b0;

    typedef enum logic [FAULT_W-1:0] {
        FAULT_NONE      = 2'd0,
        FAULT_EMPTY     = 2'd1,
        FAULT_COUNT_SAT = 2'd2,
        FAULT_REF_SAT   = 2'd3
    } t_fault;

    typedef enum logic [1:0] {
        S_IDLE,
        S_FETCH,
        S_EXEC
    } t_state;

    typedef struct packed {
        logic load;
        logic exec;
    } t_ctrl_cmd;

    typedef struct packed {
        logic out_stall;
    } t_dp_status;

endpackage

[rtl/csq_ram.sv]
// ----------------------------------------------------------------------------
// csq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module csq_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/csq_ctrl.sv]
// ----------------------------------------------------------------------------
// csq_ctrl
// Operation sequencer: accept a word, fetch the queue head, execute.
// ----------------------------------------------------------------------------
module csq_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  csq_pkg::t_dp_status i_status,
    output csq_pkg::t_ctrl_cmd  o_cmd
);

    import csq_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_FETCH;
                end
            end
            S_FETCH: begin
                n_state = S_EXEC;
            end
            S_EXEC: begin
                if (!i_status.out_stall) begin
                    o_cmd.exec = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

[rtl/csq_datapath.sv]
// ----------------------------------------------------------------------------
// csq_datapath
// Count register, wait counts, waiter queue and result register.
// ----------------------------------------------------------------------------
module csq_datapath #(
    parameter int NUM_PROCS   = csq_pkg::NUM_PROCS_DEF,
    parameter int COUNT_WIDTH = csq_pkg::COUNT_WIDTH_DEF,
    parameter int REF_WIDTH   = csq_pkg::REF_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [COUNT_WIDTH-1:0]        i_cfg_data,
    output logic [COUNT_WIDTH-1:0]        o_init_count,
    input  csq_pkg::t_ctrl_cmd            i_cmd,
    output csq_pkg::t_dp_status           o_status,
    input  logic [csq_pkg::FUNC_W-1:0]    i_func,
    input  logic [csq_pkg::PROC_ID_W-1:0] i_proc_id,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [COUNT_WIDTH-1:0]        o_count,
    output logic                          o_slept,
    output logic                          o_woke_valid,
    output logic [csq_pkg::PROC_ID_W-1:0] o_woke_proc,
    output logic [csq_pkg::FAULT_W-1:0]   o_fault
);

    import csq_pkg::*;

    localparam int CW        = COUNT_WIDTH;
    localparam int RW        = REF_WIDTH;
    localparam int PTR_W     = $clog2(NUM_PROCS);
    localparam int OCC_W     = $clog2(NUM_PROCS + 1);
    localparam int ID_SPACE  = 2 ** PROC_ID_W;
    localparam int REF_DEPTH = (NUM_PROCS < ID_SPACE) ? NUM_PROCS : ID_SPACE;
    localparam int IDX_W     = $clog2(REF_DEPTH);

    localparam logic [CW-1:0]    CNT_MAX  = {1'b0, {(CW-1){1'b1}}};
    localparam logic [CW-1:0]    CNT_MIN  = {1'b1, {(CW-1){1'b0}}};
    localparam logic [CW-1:0]    CNT_ONE  = CW'(1);
    localparam logic [RW-1:0]    REF_MAX  = {RW{1'b1}};
    localparam logic [RW-1:0]    REF_ONE  = RW'(1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(NUM_PROCS - 1);
    localparam logic [OCC_W-1:0] OCC_FULL = OCC_W'(NUM_PROCS);
    localparam logic [OCC_W-1:0] OCC_ONE  = OCC_W'(1);

    logic [CW-1:0]        r_init;
    logic [CW-1:0]        r_count;
    logic [PTR_W-1:0]     r_head;
    logic [PTR_W-1:0]     r_tail;
    logic [OCC_W-1:0]     r_occ;
    logic [RW-1:0]        r_refs [REF_DEPTH];
    logic [FUNC_W-1:0]    r_func;
    logic [PROC_ID_W-1:0] r_pid;
    logic                 r_out_valid;
    logic [CW-1:0]        r_out_count;
    logic                 r_out_slept;
    logic                 r_out_woke_valid;
    logic [PROC_ID_W-1:0] r_out_woke_proc;
    logic [FAULT_W-1:0]   r_out_fault;

    logic [CW-1:0]        n_count;
    logic [PTR_W-1:0]     n_head;
    logic [PTR_W-1:0]     n_tail;
    logic [OCC_W-1:0]     n_occ;
    logic [RW-1:0]        n_ref;
    logic                 ref_we;
    logic [IDX_W-1:0]     ref_idx;
    logic [RW-1:0]        ref_cur;
    logic                 fifo_we;
    logic [PROC_ID_W-1:0] fifo_head_pid;
    logic                 res_slept;
    logic                 res_woke_valid;
    logic [PROC_ID_W-1:0] res_woke_proc;
    t_fault               res_fault;
    logic                 pid_ok;
    logic                 cnt_le_zero;

    csq_ram #(
        .WIDTH (PROC_ID_W),
        .DEPTH (NUM_PROCS)
    ) u_waiter_fifo (
        .i_clk   (i_clk),
        .i_we    (fifo_we),
        .i_waddr (r_tail),
        .i_wdata (r_pid),
        .i_raddr (r_head),
        .o_rdata (fifo_head_pid)
    );

    assign pid_ok      = (32'(r_pid) < NUM_PROCS);
    assign cnt_le_zero = r_count[CW-1] || (r_count == '0);
    assign ref_idx     = (r_func == FUNC_SIGNAL) ? fifo_head_pid[IDX_W-1:0] : r_pid[IDX_W-1:0];
    assign ref_cur     = r_refs[ref_idx];

    always_comb begin
        n_count        = r_count;
        n_head         = r_head;
        n_tail         = r_tail;
        n_occ          = r_occ;
        n_ref          = ref_cur;
        ref_we         = 1'b0;
        fifo_we        = 1'b0;
        res_slept      = 1'b0;
        res_woke_valid = 1'b0;
        res_woke_proc  = '0;
        res_fault      = FAULT_NONE;
        unique case (r_func)
            FUNC_WAIT: begin
                if (!pid_ok) begin
                    n_count = r_count;
                end else if (r_count == CNT_MIN) begin
                    res_fault = FAULT_COUNT_SAT;
                end else if (cnt_le_zero) begin
                    if (ref_cur == REF_MAX) begin
                        res_fault = FAULT_REF_SAT;
                    end else begin
                        n_count = r_count - CNT_ONE;
                        if ((ref_cur == '0) && (r_occ < OCC_FULL)) begin
                            fifo_we = 1'b1;
                            n_tail  = (r_tail == PTR_LAST) ? '0 : r_tail + PTR_W'(1);
                            n_occ   = r_occ + OCC_ONE;
                        end
                        ref_we    = 1'b1;
                        n_ref     = ref_cur + REF_ONE;
                        res_slept = 1'b1;
                    end
                end else begin
                    n_count = r_count - CNT_ONE;
                end
            end
            FUNC_SIGNAL: begin
                if (r_count == CNT_MAX) begin
                    res_fault = FAULT_COUNT_SAT;
                end else begin
                    n_count = r_count + CNT_ONE;
                    if (r_count[CW-1]) begin
                        if (r_occ == '0) begin
                            res_fault = FAULT_EMPTY;
                        end else begin
                            ref_we = 1'b1;
                            n_ref  = (ref_cur == '0) ? '0 : ref_cur - REF_ONE;
                            if (ref_cur <= REF_ONE) begin
                                n_head         = (r_head == PTR_LAST) ? '0 : r_head + PTR_W'(1);
                                n_occ          = r_occ - OCC_ONE;
                                res_woke_valid = 1'b1;
                                res_woke_proc  = fifo_head_pid;
                            end
                        end
                    end
                end
            end
            default: begin
                n_count = r_count;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init  <= '0;
            r_count <= '0;
            r_head  <= '0;
            r_tail  <= '0;
            r_occ   <= '0;
            for (int i = 0; i < REF_DEPTH; i++) begin
                r_refs[i] <= '0;
            end
        end else if (i_cfg_we) begin
            r_init  <= i_cfg_data;
            r_count <= i_cfg_data;
            r_head  <= '0;
            r_tail  <= '0;
            r_occ   <= '0;
            for (int i = 0; i < REF_DEPTH; i++) begin
                r_refs[i] <= '0;
            end
        end else if (i_cmd.exec) begin
            r_count <= n_count;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_occ   <= n_occ;
            if (ref_we) begin
                r_refs[ref_idx] <= n_ref;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.exec) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func <= i_func;
            r_pid  <= i_proc_id;
        end
        if (i_cmd.exec) begin
            r_out_count      <= n_count;
            r_out_slept      <= res_slept;
            r_out_woke_valid <= res_woke_valid;
            r_out_woke_proc  <= res_woke_proc;
            r_out_fault      <= res_fault;
        end
    end

    assign o_status.out_stall = r_out_valid && !i_out_ready;
    assign o_init_count       = r_init;
    assign o_out_valid        = r_out_valid;
    assign o_count            = r_out_count;
    assign o_slept            = r_out_slept;
    assign o_woke_valid       = r_out_woke_valid;
    assign o_woke_proc        = r_out_woke_proc;
    assign o_fault            = r_out_fault;

endmodule

[rtl/counting_semaphore_wait_queue.sv]
// ----------------------------------------------------------------------------
// counting_semaphore_wait_queue
// Counting semaphore with a FIFO of sleeping process ids and per-process
// wait counts.
//
//   channel   direction   handshake                  payload
//   in        input       i_in_valid / o_in_ready    i_func, i_proc_id
//   out       output      o_out_valid / i_out_ready  o_count, o_slept, o_woke_*, o_fault
//   cfg       input       APB write/read             initial_count at 0x0
//
// Each word passes through accept, head-of-queue fetch from the waiter RAM
// (registered read) and execute into the result register.
// Reset and every initial_count write load the count and empty the queue.
// A result waiting on i_out_ready holds the next word in its execute cycle.
// ----------------------------------------------------------------------------
module counting_semaphore_wait_queue #(
    parameter int NUM_PROCS   = csq_pkg::NUM_PROCS_DEF,
    parameter int COUNT_WIDTH = csq_pkg::COUNT_WIDTH_DEF,
    parameter int REF_WIDTH   = csq_pkg::REF_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [csq_pkg::APB_AW-1:0]    paddr,
    input  logic [csq_pkg::APB_DW-1:0]    pwdata,
    output logic [csq_pkg::APB_DW-1:0]    prdata,
    output logic                          pready,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [csq_pkg::FUNC_W-1:0]    i_func,
    input  logic [csq_pkg::PROC_ID_W-1:0] i_proc_id,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [COUNT_WIDTH-1:0]        o_count,
    output logic                          o_slept,
    output logic                          o_woke_valid,
    output logic [csq_pkg::PROC_ID_W-1:0] o_woke_proc,
    output logic [csq_pkg::FAULT_W-1:0]   o_fault
);

    import csq_pkg::*;

    t_ctrl_cmd              cmd;
    t_dp_status             status;
    logic                   cfg_we;
    logic [COUNT_WIDTH-1:0] init_count;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && (paddr[2] == REG_INITIAL_COUNT);
    assign prdata = (paddr[2] == REG_INITIAL_COUNT) ? APB_DW'($signed(init_count)) : '0;

    csq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    csq_datapath #(
        .NUM_PROCS   (NUM_PROCS),
        .COUNT_WIDTH (COUNT_WIDTH),
        .REF_WIDTH   (REF_WIDTH)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_data   (pwdata[COUNT_WIDTH-1:0]),
        .o_init_count (init_count),
        .i_cmd        (cmd),
        .o_status     (status),
        .i_func       (i_func),
        .i_proc_id    (i_proc_id),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_count      (o_count),
        .o_slept      (o_slept),
        .o_woke_valid (o_woke_valid),
        .o_woke_proc  (o_woke_proc),
        .o_fault      (o_fault)
    );

endmodule
